// ===== hw/rtl/afac_pkg.sv =====
// shared types, constants and helpers for the attitude frame to angle command block
package afac_pkg;

    localparam int FRAME_BYTES_DEF   = 23;
    localparam int COMMAND_BYTES_DEF = 14;

    localparam int HEADER_LEN     = 3;
    localparam int ANGLE_LOW_POS  = 19;
    localparam int ANGLE_HIGH_POS = 20;

    localparam logic [7:0] HEADER_0 = 8'hA7;
    localparam logic [7:0] HEADER_1 = 8'h7A;
    localparam logic [7:0] HEADER_2 = 8'h60;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // fixed byte slots inside the command
    localparam int SIGN_POS     = 2;
    localparam int ONES_POS     = 3;
    localparam int TENS_POS     = 4;
    localparam int HUNDREDS_POS = 5;

    // floor(x / 100) = (x * 5243) >> 19 for x up to 32768
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_100_SH = 19;
    // floor(x / 10) = (x * 205) >> 11 for x below 1024
    localparam logic [7:0]  RECIP_10    = 8'd205;
    localparam int          RECIP_10_SH = 11;

    typedef struct packed {
        logic        negative;
        logic [15:0] mag;
    } afac_desc_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } afac_out_t;

    function automatic logic [7:0] header_byte(input logic [1:0] pos);
        logic [7:0] hb;
        case (pos)
            2'd0:    hb = HEADER_0;
            2'd1:    hb = HEADER_1;
            default: hb = HEADER_2;
        endcase
        return hb;
    endfunction

endpackage

// ===== hw/rtl/afac_fifo2.sv =====
// two-entry flop queue used between stages and at the result side
module afac_fifo2 #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/afac_front.sv =====
// frame parser: header hunt, byte counting, angle capture, command descriptor
module afac_front #(
    parameter int FRAME_BYTES = afac_pkg::FRAME_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           rx_byte,
    output logic                 desc_push,
    output afac_pkg::afac_desc_t desc,
    input  logic                 desc_full
);
    import afac_pkg::*;

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       low_reg;
    logic [7:0]       high_reg;
    logic             accept;
    logic             in_header;
    logic             header_bad;
    logic             frame_end;
    logic [7:0]       angle_hi;
    logic [15:0]      raw;

    assign full       = desc_full;
    assign accept     = push & ~desc_full;
    assign in_header  = (pos_reg < POS_W'(HEADER_LEN));
    assign header_bad = in_header && (rx_byte != header_byte(pos_reg[1:0]));
    assign frame_end  = ~header_bad && (pos_reg >= LAST_POS);

    // the high angle byte may be the last byte of a short frame
    assign angle_hi = (pos_reg == POS_W'(ANGLE_HIGH_POS)) ? rx_byte : high_reg;
    assign raw      = {angle_hi, low_reg};

    assign desc_push     = accept & frame_end;
    assign desc.negative = raw[15];
    assign desc.mag      = raw[15] ? (16'd0 - raw) : raw;

    always_comb
    begin
        if (header_bad)
        begin
            pos_next = (rx_byte == HEADER_0) ? POS_W'(1) : '0;
        end
        else if (frame_end)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            low_reg  <= 8'd0;
            high_reg <= 8'd0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            if (!header_bad && pos_reg == POS_W'(ANGLE_LOW_POS))
            begin
                low_reg <= rx_byte;
            end
            if (!header_bad && pos_reg == POS_W'(ANGLE_HIGH_POS))
            begin
                high_reg <= rx_byte;
            end
        end
    end

endmodule

// ===== hw/rtl/afac_back.sv =====
// command generator: degree conversion, digit split and byte sequencing
module afac_back #(
    parameter int COMMAND_BYTES = afac_pkg::COMMAND_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 desc_valid,
    input  afac_pkg::afac_desc_t desc,
    output logic                 desc_pop,
    output logic                 out_push,
    output afac_pkg::afac_out_t  out_item,
    input  logic                 out_full
);
    import afac_pkg::*;

    localparam int IDX_W = $clog2(COMMAND_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(COMMAND_BYTES - 1);

    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             neg_reg;
    logic [8:0]       whole_reg;
    logic [5:0]       q1_reg;
    logic [3:0]       ones_reg;
    logic [28:0]      prod_whole;
    logic [16:0]      prod_q1;
    logic [5:0]       q1;
    logic [3:0]       ones;
    logic [10:0]      prod_q2;
    logic [1:0]       q2;
    logic [3:0]       tens;
    logic             is_last;
    logic [7:0]       byte_val;

    // whole degrees = magnitude / 100
    assign prod_whole = 29'(desc.mag) * 29'(RECIP_100);

    // ones digit and whole / 10, registered every cycle from whole_reg
    assign prod_q1 = 17'(whole_reg) * 17'(RECIP_10);
    assign q1      = prod_q1[RECIP_10_SH +: 6];
    assign ones    = 4'(whole_reg - 9'(q1) * 9'd10);

    // q1 is at most 32, so q1 * 26 >> 8 gives q1 / 10 exactly
    assign prod_q2 = 11'(q1_reg) * 11'd26;
    assign q2      = prod_q2[9:8];
    assign tens    = 4'(q1_reg - 6'(q2) * 6'd10);

    assign is_last  = (idx_reg == LAST_IDX);
    assign out_push = busy_reg & ~out_full;
    assign desc_pop = desc_valid & (~busy_reg | (out_push & is_last));

    always_comb
    begin
        case (idx_reg)
            IDX_W'(SIGN_POS):     byte_val = neg_reg ? CHAR_MINUS : CHAR_PLUS;
            IDX_W'(ONES_POS):     byte_val = CHAR_ZERO + 8'(ones_reg);
            IDX_W'(TENS_POS):     byte_val = CHAR_ZERO + 8'(tens);
            IDX_W'(HUNDREDS_POS): byte_val = CHAR_ZERO + 8'(q2);
            default:              byte_val = 8'd0;
        endcase
    end

    assign out_item.data = byte_val;
    assign out_item.last = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (desc_pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (out_push)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_pop)
        begin
            neg_reg   <= desc.negative;
            whole_reg <= prod_whole[RECIP_100_SH +: 9];
        end
        q1_reg   <= q1;
        ones_reg <= ones;
    end

endmodule

// ===== hw/rtl/attitude_frame_to_angle_command_core.sv =====
// top level of the attitude frame to angle command block
// Takes one sensor byte per cycle on push/full and counts bytes into frames
// that start with A7 7A 60; a bad header byte restarts the hunt. After the last
// byte of a valid frame the angle from bytes 19 and 20 becomes a command
// descriptor in a two-deep queue, and the command generator turns it into
// COMMAND_BYTES bytes (sign and three ascii digits of whole degrees) that leave
// one per cycle, while pop is held high, through a two-entry result queue on
// empty/pop. Input runs at one byte per cycle as long as fewer than two commands
// are waiting; the first command byte passes through the descriptor queue, the
// command generator and the result queue in that order.
module attitude_frame_to_angle_command_core #(
    parameter int FRAME_BYTES   = afac_pkg::FRAME_BYTES_DEF,
    parameter int COMMAND_BYTES = afac_pkg::COMMAND_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] tx_byte,
    output logic       last_byte
);
    import afac_pkg::*;

    logic       desc_push;
    logic       desc_full;
    logic       desc_empty;
    logic       desc_pop;
    afac_desc_t desc_in;
    afac_desc_t desc_out;
    logic       out_push;
    logic       out_full;
    afac_out_t  out_in;
    afac_out_t  out_head;

    afac_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .desc_push (desc_push),
        .desc      (desc_in),
        .desc_full (desc_full)
    );

    afac_fifo2 #(
        .WIDTH ($bits(afac_desc_t))
    ) u_desc_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_push),
        .wr_data (desc_in),
        .full    (desc_full),
        .rd_en   (desc_pop),
        .rd_data (desc_out),
        .empty   (desc_empty)
    );

    afac_back #(
        .COMMAND_BYTES (COMMAND_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (~desc_empty),
        .desc       (desc_out),
        .desc_pop   (desc_pop),
        .out_push   (out_push),
        .out_item   (out_in),
        .out_full   (out_full)
    );

    afac_fifo2 #(
        .WIDTH ($bits(afac_out_t))
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_in),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_head),
        .empty   (empty)
    );

    assign tx_byte   = out_head.data;
    assign last_byte = out_head.last;

endmodule
